// File: rtl/fps_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the first palindrome search block
// no dependencies

package fps_pkg;

  localparam int LINE_DEPTH = 128;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  localparam int LEN_W      = (CNT_W > 8) ? CNT_W : 8;
  localparam int SUM_W      = LEN_W + 1;

  localparam logic [7:0] MIN_LEN_RESET = 8'd4;
  localparam logic [7:0] MIN_LEN_FLOOR = 8'd2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       line_end;
  } fps_in_t;

  typedef struct packed {
    logic       found;
    logic [6:0] match_start;
    logic [7:0] match_length;
    logic [7:0] cleaned_count;
    logic       overflowed;
  } fps_out_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [CNT_W-1:0] start;
    logic [LEN_W-1:0] length;
  } fps_status_t;

endpackage

// File: rtl/fps_search.sv
`timescale 1ns / 1ps
// line store and palindrome search sequencer with one shared byte compare
// depends on fps_pkg

module fps_search import fps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              start,
  input  logic [CNT_W-1:0]  count,
  input  logic [7:0]        need,
  output fps_status_t       status
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BOUND = 4'b0010,
    S_READ  = 4'b0100,
    S_CMP   = 4'b1000
  } state_t;

  state_t state;

  logic [7:0]        mem [LINE_DEPTH];
  logic [7:0]        rd_a;
  logic [7:0]        rd_b;
  logic [CNT_W-1:0]  s;
  logic [LEN_W-1:0]  len;
  logic [ADDR_W-1:0] lo;
  logic [ADDR_W-1:0] hi;
  logic              done;
  logic              hit;
  logic [CNT_W-1:0]  hit_start;
  logic [LEN_W-1:0]  hit_len;
  logic [SUM_W-1:0]  span_end;
  logic [LEN_W-1:0]  need_w;

  assign need_w   = LEN_W'(need);
  assign span_end = SUM_W'(s) + SUM_W'(len);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[lo];
    rd_b <= mem[hi];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            s     <= '0;
            len   <= need_w;
            state <= S_BOUND;
          end
        end
        S_BOUND: begin
          if (span_end > SUM_W'(count)) begin
            if (len == need_w) begin
              // no later start can fit the minimum either
              done      <= 1'b1;
              hit       <= 1'b0;
              hit_start <= '0;
              hit_len   <= '0;
              state     <= S_IDLE;
            end else begin
              s     <= s + CNT_W'(1);
              len   <= need_w;
            end
          end else begin
            lo    <= s[ADDR_W-1:0];
            hi    <= ADDR_W'(span_end - SUM_W'(1));
            state <= S_READ;
          end
        end
        S_READ: begin
          if (lo >= hi) begin
            done      <= 1'b1;
            hit       <= 1'b1;
            hit_start <= s;
            hit_len   <= len;
            state     <= S_IDLE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_a == rd_b) begin
            lo    <= lo + ADDR_W'(1);
            hi    <= hi - ADDR_W'(1);
            state <= S_READ;
          end else begin
            len   <= len + LEN_W'(1);
            state <= S_BOUND;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status.done   = done;
  assign status.hit    = hit;
  assign status.start  = hit_start;
  assign status.length = hit_len;

endmodule

// File: rtl/first_palindrome_search_core.sv
`timescale 1ns / 1ps
// top level: byte cleaning, line collection, search control and result register
// depends on fps_pkg and fps_search
//
//   channel   signals                        transaction
//   input     in_valid, in_ready, in_item    one raw byte with its line end flag
//   output    out_valid, out_ready, out_item one search result per line
//   config    cfg_we, cfg_wdata              min_length write, no wait
//
// bytes are taken one per cycle while no search runs and no result is held
// the search takes one bound check per tried span or start step, a read and a compare
// per compared byte pair and one more read step to confirm a hit, all through the one compare unit
// res and out_item close the line; rst clears the sequencers and counts, min_length to 4
// the input stalls during a search and while an earlier result is still held

module first_palindrome_search_core import fps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  fps_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output fps_out_t out_item,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata
);

  typedef enum logic [2:0] {
    T_IDLE   = 3'b001,
    T_SEARCH = 3'b010,
    T_HOLD   = 3'b100
  } state_t;

  state_t      state;
  logic [7:0]  min_len;
  logic [7:0]  need;
  logic [CNT_W-1:0] count;
  logic        ovf;
  logic        accept;
  logic        keep;
  logic        room;
  logic [7:0]  clean_byte;
  logic        wr_en;
  logic        start;
  logic        load;
  fps_status_t status;
  fps_status_t res;

  function automatic logic is_dropped(input logic [7:0] c);
    logic d;
    d = (c == 8'd32) || (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
        (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    return d;
  endfunction

  assign in_ready   = (state == T_IDLE);
  assign accept     = in_valid && in_ready;
  assign keep       = !is_dropped(in_item.char_byte);
  assign room       = count < CNT_W'(LINE_DEPTH);
  assign clean_byte = (in_item.char_byte >= 8'd65 && in_item.char_byte <= 8'd90) ?
                      in_item.char_byte + 8'd32 : in_item.char_byte;
  assign wr_en      = accept && keep && room;
  assign start      = accept && in_item.line_end;
  assign need       = (min_len < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : min_len;
  assign load       = (state == T_HOLD) && (!out_valid || out_ready);

  fps_search u_search (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (clean_byte),
    .start   (start),
    .count   (count),
    .need    (need),
    .status  (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= MIN_LEN_RESET;
    end else if (cfg_we) begin
      min_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (accept && keep) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          if (start) begin
            state <= T_SEARCH;
          end
        end
        T_SEARCH: begin
          if (status.done) begin
            res   <= status;
            state <= T_HOLD;
          end
        end
        T_HOLD: begin
          if (load) begin
            out_valid              <= 1'b1;
            out_item.found         <= res.hit;
            out_item.match_start   <= 7'(res.start);
            out_item.match_length  <= 8'(res.length);
            out_item.cleaned_count <= 8'(count);
            out_item.overflowed    <= ovf;
            count                  <= '0;
            ovf                    <= 1'b0;
            state                  <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for first_palindrome_search_core: directed lines, a full line store and
// random text lines under three flow-control phases, checked against a local predictor
// depends on fps_pkg and the rtl top level

module testbench;
  import fps_pkg::*;

  typedef logic [7:0] text_q_t [$];

  localparam int CYCLE_LIMIT   = 5_000_000;
  localparam int SETTLE_CYCLES = 16;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  fps_in_t    in_item;
  logic       out_valid;
  logic       out_ready;
  fps_out_t   out_item;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  logic [7:0] line_chars [LINE_DEPTH];
  int         chars_kept;
  logic       chars_dropped;
  logic [7:0] min_len_reg;
  fps_out_t   pending_matches [$];

  int errors = 0;
  int bytes_sent;
  int lines_checked = 0;
  int cycles = 0;
  int send_idle_pct;
  int recv_idle_pct;

  first_palindrome_search_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lines still pending", cycles,
               pending_matches.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic bit is_stripped(logic [7:0] c);
    return c == " " || (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic bit span_is_mirror(int first, int len);
    for (int k = 0; k < len / 2; k++) begin
      if (line_chars[first + k] != line_chars[first + len - 1 - k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic fps_out_t search_first_palindrome();
    fps_out_t r;
    int need;
    r = '0;
    need = (min_len_reg < MIN_LEN_FLOOR) ? int'(MIN_LEN_FLOOR) : int'(min_len_reg);
    for (int s = 0; s < chars_kept && !r.found; s++) begin
      for (int len = need; s + len <= chars_kept; len++) begin
        if (span_is_mirror(s, len)) begin
          r.found        = 1'b1;
          r.match_start  = s[6:0];
          r.match_length = len[7:0];
          break;
        end
      end
    end
    r.cleaned_count = chars_kept[7:0];
    r.overflowed    = chars_dropped;
    return r;
  endfunction

  function automatic void predict_byte(fps_in_t item);
    logic [7:0] c;
    c = item.char_byte;
    if (!is_stripped(c)) begin
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      if (chars_kept < LINE_DEPTH) begin
        line_chars[chars_kept] = c;
        chars_kept++;
      end else begin
        chars_dropped = 1'b1;
      end
    end
    if (item.line_end) begin
      pending_matches.push_back(search_first_palindrome());
      chars_kept    = 0;
      chars_dropped = 1'b0;
    end
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    fps_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_matches.size() == 0) begin
        $error("result transaction with no line pending: %p", out_item);
        errors++;
      end else begin
        want = pending_matches.pop_front();
        check_field("found", 8'(want.found), 8'(out_item.found));
        check_field("match_start", 8'(want.match_start), 8'(out_item.match_start));
        check_field("match_length", want.match_length, out_item.match_length);
        check_field("cleaned_count", want.cleaned_count, out_item.cleaned_count);
        check_field("overflowed", 8'(want.overflowed), 8'(out_item.overflowed));
      end
      lines_checked++;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    fps_in_t item;
    item.char_byte = b;
    item.line_end  = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(item);
    bytes_sent++;
  endtask

  task automatic send_line(input text_q_t text);
    for (int i = 0; i < text.size(); i++) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_min_length(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    min_len_reg = v;
    @(posedge clk);
  endtask

  function automatic text_q_t from_text(string s);
    text_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic text_q_t repeated(logic [7:0] c, int n);
    text_q_t q;
    for (int i = 0; i < n; i++) q.push_back(c);
    return q;
  endfunction

  function automatic text_q_t random_letters(string alpha, int n);
    text_q_t q;
    for (int i = 0; i < n; i++) q.push_back(alpha[$urandom_range(alpha.len() - 1)]);
    return q;
  endfunction

  function automatic logic [7:0] pick_min_length();
    case ($urandom_range(9))
      0: begin
        return 8'd0;
      end
      1: begin
        return 8'd1;
      end
      2: begin
        return 8'd255;
      end
      3: begin
        return 8'($urandom_range(9, 40));
      end
      default: begin
        return 8'($urandom_range(2, 8));
      end
    endcase
  endfunction

  function automatic text_q_t random_line();
    text_q_t plain;
    text_q_t core;
    text_q_t text;
    string alpha;
    string marks;
    int roll;
    marks = " .,!?;:'-()[]{}~@#";
    if ($urandom_range(1) == 0) begin
      alpha = "ab";
    end else begin
      alpha = "abc0";
    end
    roll  = $urandom_range(99);
    if (roll < 18) begin
      for (int i = 0; i < $urandom_range(1, 12); i++) text.push_back(8'($urandom_range(255)));
      return text;
    end
    if (roll < 20) begin
      plain = random_letters(alpha, $urandom_range(100, 150));
    end else if (roll < 60) begin
      // letters around a mirrored core
      plain = random_letters(alpha, $urandom_range(0, 3));
      core  = random_letters("abcd", $urandom_range(1, 6));
      plain = {plain, core};
      if ($urandom_range(1)) plain.push_back(alpha[$urandom_range(alpha.len() - 1)]);
      for (int i = core.size() - 1; i >= 0; i--) plain.push_back(core[i]);
      plain = {plain, random_letters(alpha, $urandom_range(0, 3))};
    end else begin
      plain = random_letters(alpha, $urandom_range(0, 12));
    end
    foreach (plain[i]) begin
      if ($urandom_range(4) == 0) text.push_back(marks[$urandom_range(marks.len() - 1)]);
      if (plain[i] >= "a" && plain[i] <= "z" && $urandom_range(1) == 1) begin
        text.push_back(plain[i] - 8'd32);
      end else begin
        text.push_back(plain[i]);
      end
    end
    if (text.size() == 0 || $urandom_range(4) == 0) begin
      text.push_back(marks[$urandom_range(marks.len() - 1)]);
    end
    return text;
  endfunction

  task automatic test_directed();
    send_line(from_text("Abba"));
    send_line(from_text(" "));
    send_line(from_text("x,Y!y x"));
    send_line('{8'h00, 8'hff, 8'h7f, 8'h7f, 8'hff, 8'h00});
    send_line(from_text("abc"));
    wait_for_results();
  endtask

  task automatic test_min_length_extremes();
    write_min_length(8'd0);
    send_line(from_text("ab-b"));
    wait_for_results();
    write_min_length(8'd1);
    send_line(from_text("xA a"));
    wait_for_results();
    write_min_length(8'd255);
    send_line(from_text("aaaa"));
    wait_for_results();
    write_min_length(8'd2);
    send_line(from_text("a"));
    wait_for_results();
  endtask

  task automatic test_full_store();
    write_min_length(8'd128);
    send_line({repeated("A", LINE_DEPTH), from_text(".")});
    send_line(repeated("a", LINE_DEPTH + 2));
    wait_for_results();
    write_min_length(MIN_LEN_RESET);
    send_line(random_letters("ab", 140));
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int budget);
    int goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = bytes_sent + budget;
    while (bytes_sent < goal) begin
      if ($urandom_range(7) == 0) begin
        wait_for_results();
        write_min_length(pick_min_length());
      end
      send_line(random_line());
    end
    wait_for_results();
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    bytes_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    chars_kept    = 0;
    chars_dropped = 1'b0;
    min_len_reg   = MIN_LEN_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_min_length_extremes();
    test_full_store();
    test_random_traffic(29, 79, 390);
    test_random_traffic(79, 29, 390);
    test_random_traffic(0, 0, 390);

    $display("%0d bytes sent, %0d line results checked in %0d cycles", bytes_sent,
             lines_checked, cycles);
    $display("covered: directed lines, minimum length extremes, full store and three stall mixes");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fps_pkg.sv
rtl/fps_search.sv
rtl/first_palindrome_search_core.sv
tb/testbench.sv
